// ----- rtl/core/emfd_pkg.sv -----
// ----------------------------------------------------------------------------
// emfd_pkg - Shared definitions for the movable feast date unit
// Field widths, reciprocal constants for the constant divisions of the
// computus, pipeline depth and the month codes.
// ----------------------------------------------------------------------------
package emfd_pkg;

  // Field widths.
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 3;
  localparam int CMONTH_W = 2;
  localparam int DAY_W    = 5;

  // Number of register stages from the input to the output register.
  localparam int STAGES = 10;

  // Reciprocals for the constant divisions. Each one was chosen so that the
  // truncation error stays below one step of the divisor over the full
  // range of its argument.
  localparam logic [12:0] RECIP_100 = 13'd5243;   // y / 100, shift 19
  localparam logic [14:0] RECIP_19  = 15'd27595;  // y / 19,  shift 19
  localparam logic [5:0]  RECIP_25  = 6'd41;      // x / 25,  shift 10
  localparam logic [7:0]  RECIP_3   = 8'd171;     // x / 3,   shift 9
  localparam logic [10:0] RECIP_30  = 11'd1093;   // x / 30,  shift 15
  localparam logic [7:0]  RECIP_7   = 8'd147;     // x / 7,   shift 10

  // Threshold of the lunar correction term (a + 11h + 22l) / 451.
  localparam logic [8:0] CORR_LIMIT = 9'd451;

  // Month codes.
  localparam logic [MONTH_W-1:0] MON_FEB = 3'd2;
  localparam logic [MONTH_W-1:0] MON_MAR = 3'd3;
  localparam logic [MONTH_W-1:0] MON_APR = 3'd4;
  localparam logic [MONTH_W-1:0] MON_MAY = 3'd5;
  localparam logic [MONTH_W-1:0] MON_JUN = 3'd6;

endpackage

// ----- rtl/core/easter_movable_feast_dates_unit.sv -----
// ----------------------------------------------------------------------------
// easter_movable_feast_dates_unit - Easter and movable feast calculator
// Computes Easter Sunday, Good Friday, Carnival Tuesday and Corpus Christi
// from a Gregorian year with the anonymous Gregorian computus.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the input channel carries one year (in_year). For every
//   request the block delivers exactly one result on the output channel:
//   month and day of the four feasts, in request order.
//   The computus is cut into ten register stages. The divisions by 100, 19,
//   25, 3, 30 and 7 are done with reciprocal multiplications, each followed
//   by a register, so the deepest stage holds one small multiplier or one
//   short add and compare chain.
//   One request can be accepted in every cycle in which in_stall is low;
//   the sustained rate is one year per clock while no result is held.
//   The whole pipe advances as one: it holds only when the output register
//   carries a valid result and out_stall is high. In that case in_stall is
//   raised in the same cycle and every stage keeps its contents, so nothing
//   is dropped or repeated. Empty slots in the pipe are not squeezed out.
//   A synchronous low on rst_n clears all valid bits; the payload registers
//   are not reset. There are no configuration registers.
// ----------------------------------------------------------------------------
module easter_movable_feast_dates_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [emfd_pkg::YEAR_W-1:0]    in_year,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [emfd_pkg::MONTH_W-1:0]   out_easter_month,
  output logic [emfd_pkg::DAY_W-1:0]     out_easter_day,
  output logic [emfd_pkg::MONTH_W-1:0]   out_good_friday_month,
  output logic [emfd_pkg::DAY_W-1:0]     out_good_friday_day,
  output logic [emfd_pkg::CMONTH_W-1:0]  out_carnival_month,
  output logic [emfd_pkg::DAY_W-1:0]     out_carnival_day,
  output logic [emfd_pkg::MONTH_W-1:0]   out_corpus_month,
  output logic [emfd_pkg::DAY_W-1:0]     out_corpus_day
);
  import emfd_pkg::*;

  // Pipe advance: only a valid result held by the receiver stops it.
  logic adv;
  logic [STAGES-1:0] vld_r;

  assign adv      = !(vld_r[STAGES-1] && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[STAGES-2:0], in_valid};
    end
  end

  // Stage 1: century (y / 100) and the quotient y / 19.
  logic [YEAR_W-1:0] y1_r;
  logic [7:0]        b1_r, b1_nxt;
  logic [9:0]        q1_r, q1_nxt;
  logic [26:0]       p100;
  logic [28:0]       p19;

  always_comb begin
    p100   = 27'(in_year) * 27'(RECIP_100);
    p19    = 29'(in_year) * 29'(RECIP_19);
    b1_nxt = p100[26:19];
    q1_nxt = p19[28:19];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y1_r <= in_year;
      b1_r <= b1_nxt;
      q1_r <= q1_nxt;
    end
  end

  // Stage 2: golden number a, year in century c, and f = (b + 8) / 25.
  logic [1:0]  y2_r;
  logic [7:0]  b2_r;
  logic [4:0]  a2_r, a2_nxt;
  logic [6:0]  c2_r, c2_nxt;
  logic [2:0]  f2_r, f2_nxt;
  logic [13:0] c_full, a_full, fp;

  always_comb begin
    c_full = y1_r - 14'(b1_r) * 14'd100;
    a_full = y1_r - 14'(q1_r) * 14'd19;
    fp     = 14'(b1_r + 8'd8) * 14'(RECIP_25);
    c2_nxt = c_full[6:0];
    a2_nxt = a_full[4:0];
    f2_nxt = fp[12:10];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y2_r <= y1_r[1:0];
      b2_r <= b1_r;
      a2_r <= a2_nxt;
      c2_r <= c2_nxt;
      f2_r <= f2_nxt;
    end
  end

  // Stage 3: g = (b - f + 1) / 3, split of c and b, leap-year flag.
  logic [4:0]  a3_r;
  logic [7:0]  b3_r;
  logic [5:0]  g3_r, g3_nxt;
  logic [1:0]  e3_r, k3_r;
  logic [4:0]  i3_r;
  logic        leap3_r, leap3_nxt;
  logic [7:0]  gx;
  logic [15:0] gp;

  always_comb begin
    gx        = b2_r - 8'(f2_r) + 8'd1;
    gp        = 16'(gx) * 16'(RECIP_3);
    g3_nxt    = gp[14:9];
    leap3_nxt = (y2_r == 2'd0) && ((c2_r != 7'd0) || (b2_r[1:0] == 2'd0));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a3_r    <= a2_r;
      b3_r    <= b2_r;
      g3_r    <= g3_nxt;
      e3_r    <= b2_r[1:0];
      i3_r    <= c2_r[6:2];
      k3_r    <= c2_r[1:0];
      leap3_r <= leap3_nxt;
    end
  end

  // Stage 4: argument of the epact, 19a + b - d - g + 15 (always >= 0).
  logic [9:0] v4_r, v4_nxt;
  logic [4:0] a4_r, i4_r;
  logic [1:0] e4_r, k4_r;
  logic       leap4_r;

  always_comb begin
    v4_nxt = 10'(a3_r) * 10'd19 + 10'(b3_r) + 10'd15 - 10'(b3_r[7:2]) - 10'(g3_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v4_r    <= v4_nxt;
      a4_r    <= a3_r;
      e4_r    <= e3_r;
      i4_r    <= i3_r;
      k4_r    <= k3_r;
      leap4_r <= leap3_r;
    end
  end

  // Stage 5: quotient of the epact argument by 30.
  logic [9:0]  v5_r;
  logic [4:0]  hq5_r, a5_r, i5_r;
  logic [1:0]  e5_r, k5_r;
  logic        leap5_r;
  logic [20:0] hp;

  always_comb begin
    hp = 21'(v4_r) * 21'(RECIP_30);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v5_r    <= v4_r;
      hq5_r   <= hp[19:15];
      a5_r    <= a4_r;
      e5_r    <= e4_r;
      i5_r    <= i4_r;
      k5_r    <= k4_r;
      leap5_r <= leap4_r;
    end
  end

  // Stage 6: epact h and the weekday argument 32 + 2e + 2i - h - k.
  logic [4:0] h6_r, a6_r;
  logic [6:0] w6_r, w6_nxt;
  logic       leap6_r;
  logic [9:0] h_full;

  always_comb begin
    h_full = v5_r - 10'(hq5_r) * 10'd30;
    w6_nxt = 7'd32 + {4'd0, e5_r, 1'b0} + {1'b0, i5_r, 1'b0}
           - 7'(h_full[4:0]) - 7'(k5_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h6_r    <= h_full[4:0];
      w6_r    <= w6_nxt;
      a6_r    <= a5_r;
      leap6_r <= leap5_r;
    end
  end

  // Stage 7: quotient of the weekday argument by 7.
  logic [4:0]  h7_r, a7_r;
  logic [6:0]  w7_r;
  logic [3:0]  lq7_r;
  logic        leap7_r;
  logic [14:0] lp;

  always_comb begin
    lp = 15'(w6_r) * 15'(RECIP_7);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h7_r    <= h6_r;
      w7_r    <= w6_r;
      lq7_r   <= lp[13:10];
      a7_r    <= a6_r;
      leap7_r <= leap6_r;
    end
  end

  // Stage 8: weekday offset l.
  logic [4:0] h8_r, a8_r;
  logic [2:0] l8_r;
  logic       leap8_r;
  logic [6:0] l_full;

  always_comb begin
    l_full = w7_r - 7'(lq7_r) * 7'd7;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h8_r    <= h7_r;
      l8_r    <= l_full[2:0];
      a8_r    <= a7_r;
      leap8_r <= leap7_r;
    end
  end

  // Stage 9: lunar correction m and the Easter ordinal counted from the
  // last day of February (March 1 is 1). It lies between 22 and 56.
  logic [5:0] n9_r, n9_nxt;
  logic       leap9_r;
  logic [8:0] corr;
  logic       m9;

  always_comb begin
    corr   = 9'(a8_r) + 9'(h8_r) * 9'd11 + 9'(l8_r) * 9'd22;
    m9     = (corr >= CORR_LIMIT);
    n9_nxt = 6'(h8_r) + 6'(l8_r) + 6'd22 - (m9 ? 6'd7 : 6'd0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n9_r    <= n9_nxt;
      leap9_r <= leap8_r;
    end
  end

  // Stage 10: split the ordinal into month and day for each feast.
  logic [MONTH_W-1:0]  em_r, em_nxt, gm_r, gm_nxt, pm_r, pm_nxt;
  logic [CMONTH_W-1:0] cm_r, cm_nxt;
  logic [DAY_W-1:0]    ed_r, ed_nxt, gd_r, gd_nxt, cd_r, cd_nxt, pd_r, pd_nxt;
  logic [5:0]          n_gf, feb_len, n_car;

  always_comb begin
    // Easter Sunday.
    if (n9_r <= 6'd31) begin
      em_nxt = MON_MAR;
      ed_nxt = n9_r[4:0];
    end else begin
      em_nxt = MON_APR;
      ed_nxt = 5'(n9_r - 6'd31);
    end

    // Good Friday, two days earlier; never earlier than March 20.
    n_gf = n9_r - 6'd2;
    if (n_gf <= 6'd31) begin
      gm_nxt = MON_MAR;
      gd_nxt = n_gf[4:0];
    end else begin
      gm_nxt = MON_APR;
      gd_nxt = 5'(n_gf - 6'd31);
    end

    // Carnival Tuesday, 47 days earlier; February length follows the
    // Gregorian leap-year rule.
    feb_len = leap9_r ? 6'd29 : 6'd28;
    n_car   = feb_len + n9_r - 6'd47;
    if (n9_r > 6'd47) begin
      cm_nxt = MON_MAR[CMONTH_W-1:0];
      cd_nxt = 5'(n9_r - 6'd47);
    end else begin
      cm_nxt = MON_FEB[CMONTH_W-1:0];
      cd_nxt = n_car[4:0];
    end

    // Corpus Christi, 60 days later; May ends at ordinal 92.
    if (n9_r <= 6'd32) begin
      pm_nxt = MON_MAY;
      pd_nxt = 5'(n9_r - 6'd1);
    end else begin
      pm_nxt = MON_JUN;
      pd_nxt = 5'(n9_r - 6'd32);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      em_r <= em_nxt;
      ed_r <= ed_nxt;
      gm_r <= gm_nxt;
      gd_r <= gd_nxt;
      cm_r <= cm_nxt;
      cd_r <= cd_nxt;
      pm_r <= pm_nxt;
      pd_r <= pd_nxt;
    end
  end

  assign out_valid             = vld_r[STAGES-1];
  assign out_easter_month      = em_r;
  assign out_easter_day        = ed_r;
  assign out_good_friday_month = gm_r;
  assign out_good_friday_day   = gd_r;
  assign out_carnival_month    = cm_r;
  assign out_carnival_day      = cd_r;
  assign out_corpus_month      = pm_r;
  assign out_corpus_day        = pd_r;

  // Easter always falls between March 22 and April 25.
  a_easter_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_easter_month == MON_MAR && out_easter_day >= 5'd22) ||
                   (out_easter_month == MON_APR && out_easter_day <= 5'd25)))
    else $error("Easter date outside its window");

  // Good Friday lies in April only when Easter is in April.
  a_friday_month: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_good_friday_month == MON_APR) |-> (out_easter_month == MON_APR))
    else $error("Good Friday month inconsistent with Easter");

  // A held result must keep the whole pipe frozen and the input stalled.
  a_hold_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> (in_stall && !adv))
    else $error("Pipe advanced while the output was held");

endmodule
